/* src/masked_byte_pattern_search_unit_defines.svh */
// ----------------------------------------------------------------------------
// Masked byte pattern search unit: assertion macros
// Shared property forms for the port-level checker.
// ----------------------------------------------------------------------------
`ifndef MASKED_BYTE_PATTERN_SEARCH_UNIT_DEFINES_SVH
`define MASKED_BYTE_PATTERN_SEARCH_UNIT_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define MBPS_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define MBPS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/mbps_pkg.sv */
// ----------------------------------------------------------------------------
// Masked byte pattern search package
// Types and constants shared by the controller, datapath and top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mbps_pkg;

  // Stream payload widths.
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 64;

  // Configuration register indexes.
  localparam logic CFG_PATTERN_LENGTH = 1'b0;
  localparam logic CFG_REGION_BASE    = 1'b1;

  // Item kinds carried on the input tuser bit.
  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_SCAN = 1'b1;

  // Controller states.
  typedef enum logic {
    ST_IDLE,
    ST_PEND
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_we;
    logic scan_step;
    logic end_region;
    logic capture;
    logic out_load;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic full;
    logic reported;
  } dp_status_t;

endpackage

/* src/masked_byte_pattern_search_unit.sv */
// ----------------------------------------------------------------------------
// Masked byte pattern search unit
// Finds the first occurrence of a byte pattern with wildcard positions in a
// streamed memory region and reports its address, or a miss at region end.
//
// Channel   Dir  Payload (lowest bit first)
// s_axis    in   tdata: entry_index, pattern_byte, care, data_byte; tuser: req_type;
//                tlast: last
// m_axis    out  tdata: match_address; tuser: found
// cfg       in   index 0 pattern_length, index 1 region_base
//
// Load items and scan items that give no result leave the input ready.
// A result-producing scan item closes the input while the address add
// (region base plus start offset) fills the output register; the input
// stays closed while a previous result waits on m_axis_tready.
// Reset is synchronous; the pattern store keeps its contents over reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module masked_byte_pattern_search_unit
  import mbps_pkg::*;
#(
  parameter int MAX_PATTERN  = 64,
  parameter int OFFSET_WIDTH = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  // Configuration write port.
  input  logic                   cfg_we,
  input  logic                   cfg_index,
  input  logic [63:0]            cfg_data,
  // Input stream.
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // entry_index, pattern_byte, care, data_byte
  input  logic                   s_axis_tuser,  // req_type
  input  logic                   s_axis_tlast,
  // Result stream.
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,  // match_address
  output logic                   m_axis_tuser   // found
);

  dp_cmd_t    cmd;
  dp_status_t status;

  mbps_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .status        (status),
    .cmd           (cmd)
  );

  mbps_datapath #(
    .MAX_PATTERN  (MAX_PATTERN),
    .OFFSET_WIDTH (OFFSET_WIDTH)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .entry_index   (s_axis_tdata[5:0]),
    .pattern_byte  (s_axis_tdata[13:6]),
    .care          (s_axis_tdata[14]),
    .data_byte     (s_axis_tdata[22:15]),
    .cmd           (cmd),
    .status        (status),
    .found         (m_axis_tuser),
    .match_address (m_axis_tdata)
  );

endmodule

/* src/mbps_datapath.sv */
// ----------------------------------------------------------------------------
// Masked byte pattern search datapath
// Pattern store, prefix-match vector, offset counter and result registers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mbps_datapath
  import mbps_pkg::*;
#(
  parameter int MAX_PATTERN  = 64,
  parameter int OFFSET_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [63:0] cfg_data,
  input  logic [5:0]  entry_index,
  input  logic [7:0]  pattern_byte,
  input  logic        care,
  input  logic [7:0]  data_byte,
  input  dp_cmd_t     cmd,
  output dp_status_t  status,
  output logic        found,
  output logic [63:0] match_address
);

  localparam int IDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

  // Pattern store: each entry feeds its own comparator lane.
  logic [7:0]              expected [MAX_PATTERN];
  logic                    care_q   [MAX_PATTERN];

  logic [MAX_PATTERN-1:0]  partial;
  logic [MAX_PATTERN-1:0]  partial_next;
  logic [OFFSET_WIDTH-1:0] byte_offset;
  logic                    match_reported;
  logic [6:0]              pattern_length;
  logic [63:0]             region_base;

  logic                    found_q;
  logic [OFFSET_WIDTH-1:0] start_q;

  logic [8:0]              pl_ext;
  logic [IDX_W-1:0]        len_m1;
  logic                    full;
  logic [OFFSET_WIDTH-1:0] start;

  // Active length minus one: zero acts as one, large values saturate.
  always_comb begin
    pl_ext = 9'(pattern_length);
    if (pl_ext == 9'd0) begin
      len_m1 = '0;
    end else if (pl_ext > 9'(MAX_PATTERN)) begin
      len_m1 = IDX_W'(MAX_PATTERN - 1);
    end else begin
      len_m1 = IDX_W'(pl_ext - 9'd1);
    end
  end

  // One compare lane per pattern entry; the prefix vector shifts by one.
  always_comb begin
    for (int j = 0; j < MAX_PATTERN; j++) begin
      partial_next[j] = (IDX_W'(j) <= len_m1)
                        && ((j == 0) ? 1'b1 : partial[(j == 0) ? 0 : j - 1])
                        && (!care_q[j] || (expected[j] == data_byte));
    end
  end

  assign full  = partial_next[len_m1];
  assign start = byte_offset - OFFSET_WIDTH'(len_m1);

  assign status.full     = full;
  assign status.reported = match_reported;

  // Pattern entry writes; indexes past the store are dropped.
  always_ff @(posedge clk) begin
    for (int j = 0; j < MAX_PATTERN; j++) begin
      if (cmd.load_we && (int'(entry_index) == j)) begin
        expected[j] <= pattern_byte;
        care_q[j]   <= care;
      end
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_length <= 7'd1;
      region_base    <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_PATTERN_LENGTH: pattern_length <= cfg_data[6:0];
        CFG_REGION_BASE:    region_base    <= cfg_data;
      endcase
    end
  end

  // Scan state; the last byte of a region clears it all.
  always_ff @(posedge clk) begin
    if (rst) begin
      partial        <= '0;
      byte_offset    <= '0;
      match_reported <= 1'b0;
    end else if (cmd.end_region) begin
      partial        <= '0;
      byte_offset    <= '0;
      match_reported <= 1'b0;
    end else if (cmd.scan_step) begin
      partial     <= partial_next;
      byte_offset <= byte_offset + OFFSET_WIDTH'(1);
      if (full) begin
        match_reported <= 1'b1;
      end
    end
  end

  // Pending result: hit flag and start offset.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      found_q <= full;
      start_q <= start;
    end
  end

  // Output register: base plus start offset, zero on a miss.
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      found         <= found_q;
      match_address <= found_q ? (region_base + 64'(start_q)) : 64'd0;
    end
  end

endmodule

/* src/mbps_ctrl.sv */
// ----------------------------------------------------------------------------
// Masked byte pattern search controller
// Handshakes, command decode and output register occupancy.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mbps_ctrl
  import mbps_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic       s_axis_tuser,
  input  logic       s_axis_tlast,
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  state_t state;
  state_t state_next;
  logic   out_valid;
  logic   out_valid_next;
  logic   accept;
  logic   is_scan;
  logic   has_result;

  // State and output occupancy registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  assign s_axis_tready = (state == ST_IDLE);
  assign m_axis_tvalid = out_valid;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign is_scan       = (s_axis_tuser == REQ_SCAN);
  // A hit, or the last byte of a region that saw no hit.
  assign has_result    = is_scan && !status.reported && (status.full || s_axis_tlast);

  // Next state and commands.
  always_comb begin
    state_next     = state;
    out_valid_next = out_valid && !m_axis_tready;
    cmd            = '0;
    unique case (state)
      ST_IDLE: begin
        cmd.load_we    = accept && !is_scan;
        cmd.scan_step  = accept && is_scan && !status.reported;
        cmd.end_region = accept && is_scan && s_axis_tlast;
        cmd.capture    = accept && has_result;
        if (accept && has_result) begin
          state_next = ST_PEND;
        end
      end
      ST_PEND: begin
        if (!out_valid || m_axis_tready) begin
          cmd.out_load   = 1'b1;
          out_valid_next = 1'b1;
          state_next     = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

/* src/mbps_checker.sv */
// ----------------------------------------------------------------------------
// Masked byte pattern search checker
// Port-level properties of the search unit, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "masked_byte_pattern_search_unit_defines.svh"

module mbps_checker
  import mbps_pkg::*;
(
  input logic                   clk,
  input logic                   rst,
  input logic                   s_axis_tvalid,
  input logic                   s_axis_tready,
  input logic                   m_axis_tvalid,
  input logic                   m_axis_tready,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata,
  input logic                   m_axis_tuser
);

  logic stalled;
  logic out_xfer;

  assign stalled  = m_axis_tvalid && !m_axis_tready;
  assign out_xfer = m_axis_tvalid && m_axis_tready;

  // A stalled result keeps its payload.
  `MBPS_ASSERT_NEXT(a_out_hold, clk, rst, stalled, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled result changed")

  // A miss always reports a zero address.
  `MBPS_ASSERT_SAME(a_miss_zero, clk, rst, m_axis_tvalid && !m_axis_tuser, m_axis_tdata == '0, "miss with nonzero address")

  // No result is shown right after reset.
  `MBPS_ASSERT_SAME(a_reset_empty, clk, rst, $past(rst), !m_axis_tvalid, "result valid after reset")

  // A new result needs the address stage, so two transfers are never back to back
  // unless the input was closed in between.
  `MBPS_ASSERT_NEXT(a_result_spacing, clk, rst, out_xfer && s_axis_tready, !(m_axis_tvalid && !$past(stalled) && $past(s_axis_tready) && $past(out_xfer) && m_axis_tvalid && s_axis_tready), "result appeared without address stage")

endmodule

bind masked_byte_pattern_search_unit mbps_checker u_mbps_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
